// File: hw/rtl/gfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types, generator rows and helper functions for the Golay (24,12)
// frame decoder pipeline.
// ----------------------------------------------------------------------------
package gfd_pkg;

  localparam int unsigned GFD_W = 12;

  // Generator rows; data bit j selects row 11 - j.
  localparam logic [GFD_W-1:0] GFD_ROWS [GFD_W] = '{
    12'hDC5, 12'hB8B, 12'h717, 12'hE2D, 12'hC5B, 12'h8B7,
    12'h16F, 12'h2DD, 12'h5B9, 12'hB71, 12'h6E3, 12'hFFE
  };

  // Stage 2 result: syndromes of one frame.
  typedef struct packed {
    logic             valid;
    logic [GFD_W-1:0] data;
    logic [GFD_W-1:0] s;
    logic [GFD_W-1:0] q;
  } gfd_synd_t;

  // Stage 3 result: weight checks of one frame.
  typedef struct packed {
    logic                  valid;
    logic [GFD_W-1:0]      data;
    logic [GFD_W-1:0]      q;
    logic                  s_ok;
    logic [1:0]            s_wt;
    logic                  q_ok;
    logic [1:0]            q_wt;
    logic [GFD_W-1:0]      d_hit;
    logic [GFD_W-1:0][1:0] d_wt;
    logic [GFD_W-1:0]      p_hit;
    logic [GFD_W-1:0][1:0] p_wt;
  } gfd_class_t;

  function automatic logic [GFD_W-1:0] gfd_mult(input logic [GFD_W-1:0] w);
    logic [GFD_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < GFD_W; j++) begin
      if (w[j]) acc = acc ^ GFD_ROWS[GFD_W-1-j];
    end
    return acc;
  endfunction

  function automatic logic [3:0] gfd_weight(input logic [GFD_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < GFD_W; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gfd_syndrome.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfd_syndrome
// Pipeline stage: parity and data syndromes of one stripped Golay word.
// ----------------------------------------------------------------------------
module gfd_syndrome
  import gfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [GFD_W-1:0] data,
  input  wire logic [GFD_W-1:0] parity,
  output gfd_synd_t             synd
);

  always_ff @(posedge clk) begin
    synd.data <= data;
    synd.s    <= gfd_mult(data) ^ parity;
    synd.q    <= gfd_mult(parity) ^ data;
    if (rst) begin
      synd.valid <= 1'b0;
    end else begin
      synd.valid <= in_valid;
    end
  end

  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    synd.valid == $past(in_valid))
    else $error("syndrome valid lost or invented");

  a_data_follows: assert property (@(posedge clk) disable iff (rst)
    synd.valid |-> synd.data == $past(data))
    else $error("syndrome data mismatch");

  a_s_zero_clean: assert property (@(posedge clk) disable iff (rst)
    (in_valid && gfd_mult(data) == parity) |=> synd.s == '0)
    else $error("clean word gives nonzero syndrome");

endmodule
`default_nettype wire

// File: hw/rtl/gfd_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfd_classify
// Pipeline stage: weight tests of both syndromes and of every one-row
// correction candidate.
// ----------------------------------------------------------------------------
module gfd_classify
  import gfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire gfd_synd_t synd,
  output gfd_class_t     cls
);

  logic [3:0]            ws;
  logic [3:0]            wq;
  logic [GFD_W-1:0][3:0] wd;
  logic [GFD_W-1:0][3:0] wp;

  always_comb begin
    ws = gfd_weight(synd.s);
    wq = gfd_weight(synd.q);
    for (int i = 0; i < GFD_W; i++) begin
      wd[i] = gfd_weight(synd.s ^ GFD_ROWS[i]);
      wp[i] = gfd_weight(synd.q ^ GFD_ROWS[i]);
    end
  end

  always_ff @(posedge clk) begin
    cls.data <= synd.data;
    cls.q    <= synd.q;
    cls.s_ok <= (ws <= 4'd3);
    cls.s_wt <= ws[1:0];
    cls.q_ok <= (wq <= 4'd3);
    cls.q_wt <= wq[1:0];
    for (int i = 0; i < GFD_W; i++) begin
      cls.d_hit[i] <= (wd[i] <= 4'd2);
      cls.d_wt[i]  <= wd[i][1:0];
      cls.p_hit[i] <= (wp[i] <= 4'd2);
      cls.p_wt[i]  <= wp[i][1:0];
    end
    if (rst) begin
      cls.valid <= 1'b0;
    end else begin
      cls.valid <= synd.valid;
    end
  end

  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    cls.valid == $past(synd.valid))
    else $error("classify valid lost or invented");

  a_zero_syndrome_ok: assert property (@(posedge clk) disable iff (rst)
    (synd.valid && synd.s == '0) |=> (cls.s_ok && cls.s_wt == 2'd0))
    else $error("zero syndrome not accepted");

  a_q_passes: assert property (@(posedge clk) disable iff (rst)
    cls.valid |-> cls.q == $past(synd.q))
    else $error("data syndrome mismatch");

endmodule
`default_nettype wire

// File: hw/rtl/golay_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// golay_frame_decoder
// Golay (24,12) decoder for one 30-bit frame with complement bits.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+------------------------
//   input    | frame_bits[29:0]                       | start, busy
//   result   | data_word[11:0], bit_errors, uncorrectable | done (one-cycle strobe)
//
// A transaction is taken at every edge with start high and busy low, one per
// cycle. Four register stages (strip, syndrome, weight tests, rule select):
// done and the result come out of the rule-select register together. busy is
// registered: reset sets it and any edge without reset clears it; reset
// clears all stage valid bits. The receiver cannot stall, so the pipeline
// never holds.
// ----------------------------------------------------------------------------
module golay_frame_decoder
  import gfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [29:0] frame_bits,
  output logic             done,
  output logic [11:0]      data_word,
  output logic [1:0]       bit_errors,
  output logic             uncorrectable
);

  logic             v1;
  logic [GFD_W-1:0] data1;
  logic [GFD_W-1:0] parity1;
  gfd_synd_t        synd;
  gfd_class_t       cls;

  logic             d_any;
  logic [GFD_W-1:0] d_bits;
  logic [1:0]       d_err;
  logic             p_any;
  logic [GFD_W-1:0] p_bits;
  logic [1:0]       p_err;
  logic [GFD_W-1:0] data_next;
  logic [1:0]       err_next;
  logic             unc_next;

  // Stage 1: drop complement bits, split into data and parity.
  always_ff @(posedge clk) begin
    parity1 <= {frame_bits[28:25], frame_bits[23:20], frame_bits[18:15]};
    // All three data nibbles come from the last three groups.
    data1   <= {frame_bits[13:10], frame_bits[8:5], frame_bits[3:0]};
    if (rst) begin
      v1   <= 1'b0;
      busy <= 1'b1;
    end else begin
      v1   <= start && !busy;
      busy <= 1'b0;
    end
  end

  gfd_syndrome u_syndrome (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .data     (data1),
    .parity   (parity1),
    .synd     (synd)
  );

  gfd_classify u_classify (
    .clk  (clk),
    .rst  (rst),
    .synd (synd),
    .cls  (cls)
  );

  // Stage 4: first matching rule wins; higher rows take priority.
  always_comb begin
    d_any  = 1'b0;
    d_bits = '0;
    d_err  = '0;
    p_any  = 1'b0;
    p_bits = '0;
    p_err  = '0;
    for (int i = 0; i < GFD_W; i++) begin
      if (cls.d_hit[i]) begin
        d_any  = 1'b1;
        d_bits = 12'h800 >> i;
        d_err  = cls.d_wt[i] + 2'd1;
      end
      if (cls.p_hit[i]) begin
        p_any  = 1'b1;
        p_bits = cls.q ^ GFD_ROWS[i];
        p_err  = cls.p_wt[i] + 2'd1;
      end
    end

    unc_next = 1'b0;
    if (cls.s_ok) begin
      data_next = cls.data;
      err_next  = cls.s_wt;
    end else if (cls.q_ok) begin
      data_next = cls.data ^ cls.q;
      err_next  = cls.q_wt;
    end else if (d_any) begin
      data_next = cls.data ^ d_bits;
      err_next  = d_err;
    end else if (p_any) begin
      data_next = cls.data ^ p_bits;
      err_next  = p_err;
    end else begin
      data_next = '0;
      err_next  = '0;
      unc_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    data_word     <= data_next;
    bit_errors    <= err_next;
    uncorrectable <= unc_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cls.valid;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without matching transaction");

  a_unc_zero: assert property (@(posedge clk) disable iff (rst)
    (done && uncorrectable) |-> (data_word == '0 && bit_errors == 2'd0))
    else $error("uncorrectable result carries data");

  a_busy_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low right after reset");

  a_clean_pass: assert property (@(posedge clk) disable iff (rst)
    (cls.valid && cls.s_ok) |=> (data_word == $past(cls.data) && !uncorrectable))
    else $error("accepted word altered");

endmodule
`default_nettype wire
